// ===== src/aes_bc_pkg.sv =====
package aes_bc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_SIZE_MODE = 3'd0;
    localparam logic [2:0] CFG_KEY_0         = 3'd1;
    localparam logic [2:0] CFG_KEY_1         = 3'd2;
    localparam logic [2:0] CFG_KEY_2         = 3'd3;
    localparam logic [2:0] CFG_KEY_3         = 3'd4;

    // key size codes
    localparam logic [1:0] KEY_SIZE_128 = 2'd0;
    localparam logic [1:0] KEY_SIZE_192 = 2'd1;

    // round key store geometry: one 128-bit row per round key
    localparam int RK_DEPTH  = 15;
    localparam int RK_WIDTH  = 128;
    localparam int RK_ADDR_W = $clog2(RK_DEPTH);

    typedef logic [RK_ADDR_W-1:0] rk_addr_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       exp_step;
        logic [5:0] widx;
        logic [3:0] nk;
        logic       init;
        logic       round;
        logic       last;
        logic       dec;
        rk_addr_t   rd_addr;
        logic       out_load;
    } aes_bc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } aes_bc_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // multiply by x in GF(2^8) mod 0x11b
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return a[7] ? ((a << 1) ^ 8'h1b) : (a << 1);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte n of a block sits at bits 127-8n downto 120-8n
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] =
                    INV_SBOX[s[127 - 8 * (4 * c + r) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] d [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            a[k] = w[31 - 8 * k -: 8];
            d[k] = xtime(a[k]);
        end
        for (int r = 0; r < 4; r++) begin
            o[31 - 8 * r -: 8] = d[r] ^ d[(r + 1) % 4] ^ a[(r + 1) % 4]
                               ^ a[(r + 2) % 4] ^ a[(r + 3) % 4];
        end
        return o;
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
        logic [7:0] a  [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [7:0] x2;
        logic [7:0] x4;
        logic [7:0] x8;
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            a[k]  = w[31 - 8 * k -: 8];
            x2    = xtime(a[k]);
            x4    = xtime(x2);
            x8    = xtime(x4);
            m9[k] = x8 ^ a[k];
            mb[k] = x8 ^ x2 ^ a[k];
            md[k] = x8 ^ x4 ^ a[k];
            me[k] = x8 ^ x4 ^ x2;
        end
        for (int r = 0; r < 4; r++) begin
            o[31 - 8 * r -: 8] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4]
                               ^ m9[(r + 3) % 4];
        end
        return o;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] s);
        return {mix_col(s[127:96]), mix_col(s[95:64]), mix_col(s[63:32]),
                mix_col(s[31:0])};
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
                inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    endfunction

endpackage

// ===== src/aes_bc_ram.sv =====
module aes_bc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/aes_bc_ctrl.sv =====
module aes_bc_ctrl import aes_bc_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [1:0]     cfg_mode,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           s_op,
    input  aes_bc_status_t status,
    output aes_bc_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_PRE    = 3'd2;
    localparam logic [2:0] ST_INIT   = 3'd3;
    localparam logic [2:0] ST_ROUND  = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg;
    logic       ready_reg, ready_next;
    logic       dec_reg;
    logic [5:0] widx_reg, widx_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] nr;
    logic [3:0] nk;
    logic [5:0] wlast;
    logic       accept;
    logic       cfg_hit;

    // round count and key length in words
    always_comb begin
        unique case (mode_reg)
            KEY_SIZE_128: nr = 4'd10;
            KEY_SIZE_192: nr = 4'd12;
            default:      nr = 4'd14;
        endcase
    end
    assign nk     = nr - 4'd6;
    assign wlast  = {nr, 2'b11};
    assign accept = s_tvalid && s_tready;
    assign cfg_hit = cfg_wr_en && (cfg_index <= CFG_KEY_3);

    assign s_tready = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        widx_next    = widx_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.widx     = widx_reg;
        cmd.nk       = nk;
        cmd.dec      = dec_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_in = accept;
                widx_next   = '0;
                if (accept) begin
                    state_next = ready_reg ? ST_PRE : ST_EXPAND;
                end
            end
            ST_EXPAND: begin
                cmd.exp_step = 1'b1;
                widx_next    = widx_reg + 6'd1;
                if (widx_reg == wlast) begin
                    ready_next = 1'b1;
                    state_next = ST_PRE;
                end
            end
            ST_PRE: begin
                cmd.rd_addr = dec_reg ? rk_addr_t'(nr) : '0;
                state_next  = ST_INIT;
            end
            ST_INIT: begin
                cmd.init    = 1'b1;
                cmd.rd_addr = dec_reg ? rk_addr_t'(nr - 4'd1) : rk_addr_t'(1);
                step_next   = 4'd1;
                state_next  = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                cmd.last  = (step_reg == nr);
                if (step_reg == nr) begin
                    cmd.rd_addr = '0;
                    state_next  = ST_DONE;
                end else begin
                    cmd.rd_addr = dec_reg ? rk_addr_t'(nr - step_reg - 4'd1)
                                          : rk_addr_t'(step_reg + 4'd1);
                end
                step_next = step_reg + 4'd1;
            end
            ST_DONE: begin
                cmd.out_load = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // a key or key size write invalidates the schedule
        if (cfg_hit) begin
            ready_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
            mode_reg  <= KEY_SIZE_128;
            widx_reg  <= '0;
            step_reg  <= '0;
            dec_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            widx_reg  <= widx_next;
            step_reg  <= step_next;
            if (accept) begin
                dec_reg <= s_op;
            end
            if (cfg_wr_en && cfg_index == CFG_KEY_SIZE_MODE) begin
                mode_reg <= cfg_mode;
            end
        end
    end

    // expansion never runs past the last schedule word
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXPAND |-> widx_reg <= wlast)
        else $error("key expansion index out of range");

    // round step never exceeds the round count
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> step_reg >= 4'd1 && step_reg <= nr)
        else $error("round step out of range");

    // a key write always drops the schedule
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !ready_reg)
        else $error("schedule kept after key write");

    // leaving expansion means the schedule is marked ready
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EXPAND && state_next == ST_PRE && !cfg_hit |=> ready_reg)
        else $error("schedule not marked after expansion");

endmodule

// ===== src/aes_bc_datapath.sv =====
module aes_bc_datapath import aes_bc_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_index,
    input  logic [63:0]    cfg_wr_data,
    input  logic [63:0]    s_data_hi,
    input  logic [63:0]    s_data_lo,
    input  aes_bc_cmd_t    cmd,
    output aes_bc_status_t status,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_result_hi,
    output logic [63:0]    m_result_lo
);

    logic [63:0]    key_reg [4];
    logic [31:0]    win_reg [8];
    logic [31:0]    rowbuf_reg [3];
    logic [2:0]     kmod_reg;
    logic [7:0]     rcon_reg;
    logic [127:0]   blk_reg;
    logic [127:0]   st_reg;
    logic [127:0]   res_reg;
    logic           out_valid_reg;

    logic [2:0]     kmod_cur;
    logic [2:0]     kmod_last;
    logic [7:0]     rcon_cur;
    logic           first;
    logic [63:0]    key_pair;
    logic [31:0]    key_word;
    logic [31:0]    far_word;
    logic [31:0]    tmp_word;
    logic [31:0]    new_word;
    logic           rk_wr_en;
    logic [127:0]   rk_data;
    logic [127:0]   round_out;
    logic [127:0]   ss_fwd;
    logic [127:0]   ss_inv;

    // key words straight from the key registers, two per register
    assign key_pair = key_reg[cmd.widx[2:1]];
    assign key_word = cmd.widx[0] ? key_pair[31:0] : key_pair[63:32];

    // schedule recurrence, one word per cycle
    assign kmod_cur  = (cmd.widx == '0) ? 3'd0 : kmod_reg;
    assign rcon_cur  = (cmd.widx == '0) ? 8'h01 : rcon_reg;
    assign kmod_last = 3'(cmd.nk - 4'd1);
    assign first     = (cmd.widx < {2'b00, cmd.nk});

    always_comb begin
        case (cmd.nk)
            4'd4:    far_word = win_reg[3];
            4'd6:    far_word = win_reg[5];
            default: far_word = win_reg[7];
        endcase
        if (kmod_cur == 3'd0) begin
            tmp_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                     ^ {rcon_cur, 24'h000000};
        end else if (cmd.nk == 4'd8 && kmod_cur == 3'd4) begin
            tmp_word = sub_word(win_reg[0]);
        end else begin
            tmp_word = win_reg[0];
        end
        new_word = first ? key_word : (far_word ^ tmp_word);
    end

    always_ff @(posedge aclk) begin
        if (cmd.exp_step) begin
            win_reg[0] <= new_word;
            for (int j = 1; j < 8; j++) begin
                win_reg[j] <= win_reg[j-1];
            end
            kmod_reg <= (kmod_cur == kmod_last) ? 3'd0 : kmod_cur + 3'd1;
            rcon_reg <= (!first && kmod_cur == 3'd0) ? xtime(rcon_cur) : rcon_cur;
            if (cmd.widx[1:0] != 2'b11) begin
                rowbuf_reg[cmd.widx[1:0]] <= new_word;
            end
        end
    end

    // a full row of four words goes to the round key store
    assign rk_wr_en = cmd.exp_step && (cmd.widx[1:0] == 2'b11);

    aes_bc_ram #(
        .WIDTH (RK_WIDTH),
        .DEPTH (RK_DEPTH)
    ) u_rk_ram (
        .aclk    (aclk),
        .wr_en   (rk_wr_en),
        .wr_addr (cmd.widx[5:2]),
        .wr_data ({rowbuf_reg[0], rowbuf_reg[1], rowbuf_reg[2], new_word}),
        .rd_addr (cmd.rd_addr),
        .rd_data (rk_data)
    );

    // one cipher round per cycle
    assign ss_fwd = sub_shift(st_reg);
    assign ss_inv = inv_sub_shift(st_reg) ^ rk_data;

    always_comb begin
        if (cmd.dec) begin
            round_out = cmd.last ? ss_inv : inv_mix(ss_inv);
        end else begin
            round_out = (cmd.last ? ss_fwd : mix(ss_fwd)) ^ rk_data;
        end
    end

    // key registers, block, state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < 4; j++) begin
                key_reg[j] <= '0;
            end
        end else if (cfg_wr_en && cfg_index >= CFG_KEY_0 && cfg_index <= CFG_KEY_3) begin
            key_reg[2'(cfg_index - CFG_KEY_0)] <= cfg_wr_data;
        end
        if (cmd.load_in) begin
            blk_reg <= {s_data_hi, s_data_lo};
        end
        if (cmd.init) begin
            st_reg <= blk_reg ^ rk_data;
        end else if (cmd.round) begin
            st_reg <= round_out;
        end
        if (cmd.out_load) begin
            res_reg <= st_reg;
        end
    end

    // output register, independent of the input side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid    = out_valid_reg;
    assign m_result_hi = res_reg[127:64];
    assign m_result_lo = res_reg[63:0];

endmodule

// ===== src/aes_block_cipher_unit.sv =====
// AES block cipher for 128-, 192- and 256-bit keys (key size mode three acts
// as 256). Write the key size and key words on the config port while the unit
// is idle; the first block after any such write expands the schedule into a
// 15-row round key RAM at one 32-bit word per cycle (44, 52 or 60 words),
// after which it is reused. Each block, with tuser selecting encrypt (0) or
// decrypt (1), then passes from acceptance to a valid result through these
// steps: one key RAM read ahead, the initial key add, one round per cycle
// through the shared round unit, and the output register load once the
// output is free. The unit returns to idle with that load and only then
// accepts a new block. One block is in flight at a time; a finished result
// waits in the output register while the next block is accepted.
module aes_block_cipher_unit import aes_bc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // data_hi [63:0], data_lo [127:64]
    input  logic         s_tuser,   // op [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_hi [63:0], result_lo [127:64]
);

    aes_bc_cmd_t    cmd;
    aes_bc_status_t status;
    logic [63:0]    result_hi;
    logic [63:0]    result_lo;

    aes_bc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_mode  (cfg_wr_data[1:0]),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_op      (s_tuser),
        .status    (status),
        .cmd       (cmd)
    );

    aes_bc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data_hi   (s_tdata[63:0]),
        .s_data_lo   (s_tdata[127:64]),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result_hi (result_hi),
        .m_result_lo (result_lo)
    );

    assign m_tdata = {result_lo, result_hi};

endmodule
